/* sv/cgz_pkg.sv */
// Shared types, widths and register codes for the horizontal cylinder gravity block.
package cgz_pkg;

    localparam int COORD_W    = 24;
    localparam int TRIG_W     = 16;
    localparam int RAD_W      = 23;
    localparam int SCALE_W    = 32;
    localparam int GZ_W       = 48;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    localparam int MAG_W = 56;
    localparam int R2_W  = 46;
    localparam int NUM_W = MAG_W + R2_W;
    localparam int DEN_W = 50;
    localparam int QUO_W = MAG_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_SIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_COS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd6;

    localparam logic signed [TRIG_W-1:0] AXIS_COS_RESET = 16'sd32767;

    localparam logic [QUO_W-1:0] GZ_POS_LIMIT = QUO_W'((64'd1 << (GZ_W - 1)) - 64'd1);
    localparam logic [QUO_W-1:0] GZ_NEG_LIMIT = QUO_W'(64'd1 << (GZ_W - 1));

    typedef struct packed {
        logic signed [COORD_W-1:0] obs_x;
        logic signed [COORD_W-1:0] obs_y;
        logic signed [COORD_W-1:0] obs_z;
    } in_item_t;

    typedef struct packed {
        logic signed [GZ_W-1:0] gravity_z;
        logic                   divide_fault;
        logic                   saturated;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic signed [TRIG_W-1:0]  axis_sin;
        logic signed [TRIG_W-1:0]  axis_cos;
        logic [RAD_W-1:0]          radius;
        logic signed [SCALE_W-1:0] scale;
    } cfg_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             neg;
        logic             fault;
    } qent_t;

endpackage

/* sv/cgz_queue.sv */
// Short register queue between the classifying front end and the divider back end.
module cgz_queue
    import cgz_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  qent_t push_data,
    output logic  full,
    input  logic  pop,
    output qent_t head,
    output logic  empty
);

    qent_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QPTR_W:0]    count_reg;
    logic [QPTR_W:0]    count_next;

    assign full  = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* sv/cgz_front.sv */
// Front end: offsets, projection, distance and classification, seven pipeline stages.
module cgz_front
    import cgz_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    output logic     q_push,
    output qent_t    q_data,
    input  logic     q_full
);

    logic [6:0] valid_reg;
    logic [6:0] valid_next;
    logic       en;

    logic signed [24:0] s1_dx_reg, s1_dy_reg, s1_dz_reg;
    logic signed [24:0] s1_dx_next, s1_dy_next, s1_dz_next;

    logic signed [40:0] s2_psin_reg, s2_pcos_reg, s2_psin_next, s2_pcos_next;
    logic [47:0]        s2_sqx_reg, s2_sqy_reg, s2_sqz_reg;
    logic [47:0]        s2_sqx_next, s2_sqy_next, s2_sqz_next;
    logic signed [56:0] s2_pz_reg, s2_pz_next;
    logic [R2_W-1:0]    s2_r2_reg, s2_r2_next;
    logic signed [49:0] sqx_full, sqy_full, sqz_full;

    logic signed [25:0] s3_along_reg, s3_along_next;
    logic [48:0]        s3_sumxy_reg, s3_sumxy_next;
    logic [47:0]        s3_sqz_reg;
    logic signed [56:0] s3_pz_reg;
    logic [R2_W-1:0]    s3_r2_reg;
    logic signed [40:0] proj_sum;

    logic [50:0]        s4_along2_reg, s4_along2_next;
    logic [48:0]        s4_sumxy_reg;
    logic [47:0]        s4_sqz_reg;
    logic [MAG_W-1:0]   s4_mag_reg, s4_mag_next;
    logic               s4_neg_reg, s4_neg_next;
    logic [R2_W-1:0]    s4_r2_reg;
    logic signed [51:0] along2_full;
    logic signed [56:0] mag_full;

    logic [48:0]        s5_xy2_reg, s5_xy2_next;
    logic [47:0]        s5_sqz_reg;
    logic [MAG_W-1:0]   s5_mag_reg;
    logic               s5_neg_reg;
    logic [R2_W-1:0]    s5_r2_reg;
    logic signed [51:0] xy2_diff;

    logic [DEN_W-1:0]   s6_d2_reg, s6_d2_next;
    logic [63:0]        s6_pp_ll_reg, s6_pp_ll_next;
    logic [45:0]        s6_pp_lh_reg, s6_pp_lh_next;
    logic [55:0]        s6_pp_hl_reg, s6_pp_hl_next;
    logic [37:0]        s6_pp_hh_reg, s6_pp_hh_next;
    logic [MAG_W-1:0]   s6_mag_reg;
    logic               s6_neg_reg;
    logic [R2_W-1:0]    s6_r2_reg;

    qent_t              s7_entry_reg, s7_entry_next;
    logic [NUM_W-1:0]   prod;
    logic               outside;
    logic               zero_dist;

    assign en         = !(valid_reg[6] && q_full);
    assign in_stall   = !en;
    assign valid_next = {valid_reg[5:0], in_valid};
    assign q_push     = valid_reg[6] && !q_full;
    assign q_data     = s7_entry_reg;

    always_comb
    begin
        s1_dx_next = 25'(in_data.obs_x) - 25'(cfg.center_x);
        s1_dy_next = 25'(in_data.obs_y) - 25'(cfg.center_y);
        s1_dz_next = 25'(in_data.obs_z) - 25'(cfg.center_z);

        s2_psin_next = 41'(cfg.axis_sin) * 41'(s1_dx_reg);
        s2_pcos_next = 41'(cfg.axis_cos) * 41'(s1_dy_reg);
        sqx_full     = 50'(s1_dx_reg) * 50'(s1_dx_reg);
        sqy_full     = 50'(s1_dy_reg) * 50'(s1_dy_reg);
        sqz_full     = 50'(s1_dz_reg) * 50'(s1_dz_reg);
        s2_sqx_next  = sqx_full[47:0];
        s2_sqy_next  = sqy_full[47:0];
        s2_sqz_next  = sqz_full[47:0];
        s2_pz_next   = 57'(cfg.scale) * 57'(s1_dz_reg);
        s2_r2_next   = R2_W'(cfg.radius) * R2_W'(cfg.radius);

        // The arithmetic shift by fifteen rounds the projection towards minus infinity.
        proj_sum      = s2_psin_reg + s2_pcos_reg;
        s3_along_next = proj_sum[40:15];
        s3_sumxy_next = 49'(s2_sqx_reg) + 49'(s2_sqy_reg);

        along2_full    = 52'(s3_along_reg) * 52'(s3_along_reg);
        s4_along2_next = along2_full[50:0];
        s4_neg_next    = s3_pz_reg[56];
        mag_full       = s3_pz_reg[56] ? -s3_pz_reg : s3_pz_reg;
        s4_mag_next    = mag_full[MAG_W-1:0];

        xy2_diff    = $signed({3'b000, s4_sumxy_reg}) - $signed({1'b0, s4_along2_reg});
        s5_xy2_next = xy2_diff[51] ? 49'(0) : xy2_diff[48:0];

        s6_d2_next    = DEN_W'(s5_xy2_reg) + DEN_W'(s5_sqz_reg);
        s6_pp_ll_next = 64'(s5_mag_reg[31:0]) * 64'(s5_r2_reg[31:0]);
        s6_pp_lh_next = 46'(s5_mag_reg[31:0]) * 46'(s5_r2_reg[R2_W-1:32]);
        s6_pp_hl_next = 56'(s5_mag_reg[MAG_W-1:32]) * 56'(s5_r2_reg[31:0]);
        s6_pp_hh_next = 38'(s5_mag_reg[MAG_W-1:32]) * 38'(s5_r2_reg[R2_W-1:32]);

        // Inside the cylinder the divider is fed mag over one, so it passes mag through.
        prod = NUM_W'(s6_pp_ll_reg)
             + (NUM_W'(s6_pp_lh_reg) << 32)
             + (NUM_W'(s6_pp_hl_reg) << 32)
             + (NUM_W'(s6_pp_hh_reg) << 64);
        outside   = (s6_d2_reg >= DEN_W'(s6_r2_reg));
        zero_dist = (s6_d2_reg == '0);
        s7_entry_next.num   = outside ? prod : NUM_W'(s6_mag_reg);
        s7_entry_next.den   = (outside && !zero_dist) ? s6_d2_reg : DEN_W'(1);
        s7_entry_next.neg   = s6_neg_reg;
        s7_entry_next.fault = outside && zero_dist;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dx_reg     <= s1_dx_next;
            s1_dy_reg     <= s1_dy_next;
            s1_dz_reg     <= s1_dz_next;
            s2_psin_reg   <= s2_psin_next;
            s2_pcos_reg   <= s2_pcos_next;
            s2_sqx_reg    <= s2_sqx_next;
            s2_sqy_reg    <= s2_sqy_next;
            s2_sqz_reg    <= s2_sqz_next;
            s2_pz_reg     <= s2_pz_next;
            s2_r2_reg     <= s2_r2_next;
            s3_along_reg  <= s3_along_next;
            s3_sumxy_reg  <= s3_sumxy_next;
            s3_sqz_reg    <= s2_sqz_reg;
            s3_pz_reg     <= s2_pz_reg;
            s3_r2_reg     <= s2_r2_reg;
            s4_along2_reg <= s4_along2_next;
            s4_sumxy_reg  <= s3_sumxy_reg;
            s4_sqz_reg    <= s3_sqz_reg;
            s4_mag_reg    <= s4_mag_next;
            s4_neg_reg    <= s4_neg_next;
            s4_r2_reg     <= s3_r2_reg;
            s5_xy2_reg    <= s5_xy2_next;
            s5_sqz_reg    <= s4_sqz_reg;
            s5_mag_reg    <= s4_mag_reg;
            s5_neg_reg    <= s4_neg_reg;
            s5_r2_reg     <= s4_r2_reg;
            s6_d2_reg     <= s6_d2_next;
            s6_pp_ll_reg  <= s6_pp_ll_next;
            s6_pp_lh_reg  <= s6_pp_lh_next;
            s6_pp_hl_reg  <= s6_pp_hl_next;
            s6_pp_hh_reg  <= s6_pp_hh_next;
            s6_mag_reg    <= s5_mag_reg;
            s6_neg_reg    <= s5_neg_reg;
            s6_r2_reg     <= s5_r2_reg;
            s7_entry_reg  <= s7_entry_next;
        end
    end

endmodule

/* sv/cgz_back.sv */
// Back end: pipelined restoring divider, one quotient bit per stage, then saturation.
module cgz_back
    import cgz_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  qent_t     q_head,
    output logic      q_pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam int LAST = QUO_W - 1;

    logic [QUO_W-1:0] valid_reg;
    logic [QUO_W-1:0] valid_next;
    logic [DEN_W-1:0] rem_reg [QUO_W];
    logic [DEN_W-1:0] rem_next [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];
    logic [QUO_W-1:0] quo_next [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [DEN_W-1:0] den_in [QUO_W];
    logic [QUO_W-1:0] neg_reg;
    logic [QUO_W-1:0] neg_in;
    logic [QUO_W-1:0] fault_reg;
    logic [QUO_W-1:0] fault_in;
    logic [DEN_W-1:0] rem_in [QUO_W];
    logic [QUO_W-1:0] quo_in [QUO_W];
    logic [DEN_W:0]   trial [QUO_W];
    logic [QUO_W-1:0] qbit;

    logic      b_en;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    out_item_t out_data_next;
    logic [QUO_W-1:0] res;

    assign b_en       = !out_valid_reg || !out_stall;
    assign q_pop      = b_en && !q_empty;
    assign valid_next = {valid_reg[QUO_W-2:0], !q_empty};
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_comb
    begin
        rem_in[0]   = DEN_W'(q_head.num[NUM_W-1:QUO_W]);
        quo_in[0]   = q_head.num[QUO_W-1:0];
        den_in[0]   = q_head.den;
        neg_in[0]   = q_head.neg;
        fault_in[0] = q_head.fault;
        for (int k = 1; k < QUO_W; k++)
        begin
            rem_in[k]   = rem_reg[k-1];
            quo_in[k]   = quo_reg[k-1];
            den_in[k]   = den_reg[k-1];
            neg_in[k]   = neg_reg[k-1];
            fault_in[k] = fault_reg[k-1];
        end
        // Each stage shifts one numerator bit into the remainder and one quotient bit out.
        for (int k = 0; k < QUO_W; k++)
        begin
            trial[k] = {rem_in[k], quo_in[k][QUO_W-1]};
            qbit[k]  = (trial[k] >= {1'b0, den_in[k]});
            if (qbit[k])
            begin
                rem_next[k] = DEN_W'(trial[k] - {1'b0, den_in[k]});
            end
            else
            begin
                rem_next[k] = trial[k][DEN_W-1:0];
            end
            quo_next[k] = {quo_in[k][QUO_W-2:0], qbit[k]};
        end
    end

    always_comb
    begin
        res = quo_reg[LAST];
        out_data_next.divide_fault = fault_reg[LAST];
        out_data_next.saturated    = 1'b0;
        priority if (fault_reg[LAST])
        begin
            out_data_next.gravity_z = '0;
        end
        else if (neg_reg[LAST])
        begin
            if (res > GZ_NEG_LIMIT)
            begin
                out_data_next.saturated = 1'b1;
                out_data_next.gravity_z = $signed(GZ_NEG_LIMIT[GZ_W-1:0]);
            end
            else
            begin
                out_data_next.gravity_z = $signed(GZ_W'(0) - res[GZ_W-1:0]);
            end
        end
        else
        begin
            if (res > GZ_POS_LIMIT)
            begin
                out_data_next.saturated = 1'b1;
                out_data_next.gravity_z = $signed(GZ_POS_LIMIT[GZ_W-1:0]);
            end
            else
            begin
                out_data_next.gravity_z = $signed(res[GZ_W-1:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (b_en)
        begin
            valid_reg     <= valid_next;
            out_valid_reg <= valid_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_en)
        begin
            for (int k = 0; k < QUO_W; k++)
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                den_reg[k] <= den_in[k];
            end
            neg_reg      <= neg_in;
            fault_reg    <= fault_in;
            out_data_reg <= out_data_next;
        end
    end

endmodule

/* sv/cylinder_gravity_z.sv */
// Top level of the horizontal cylinder gravity block: registers, front, queue and divider.
//
//  Channel   Direction  Handshake             Payload
//  in        in         in_valid / in_stall   in_data (obs_x, obs_y, obs_z)
//  out       out        out_valid / out_stall out_data (gravity_z, divide_fault, saturated)
//  cfg       in         cfg_wr_en             cfg_index, cfg_data
//
// One transaction is taken every cycle while in_stall is low; the path runs through seven
// front stages, the queue register, 56 divider stages, one per quotient bit,
// and the output register.
// Reset clears the pipeline valid bits, the queue and the registers to their defaults.
// A stall on the output holds the divider; the front keeps going until the queue fills.
module cylinder_gravity_z
    import cgz_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic signed [COORD_W-1:0] center_x_reg;
    logic signed [COORD_W-1:0] center_y_reg;
    logic signed [COORD_W-1:0] center_z_reg;
    logic signed [TRIG_W-1:0]  axis_sin_reg;
    logic signed [TRIG_W-1:0]  axis_cos_reg;
    logic [RAD_W-1:0]          radius_reg;
    logic signed [SCALE_W-1:0] scale_reg;
    cfg_t                      cfg;

    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;
    qent_t q_push_data;
    qent_t q_head;

    assign cfg.center_x = center_x_reg;
    assign cfg.center_y = center_y_reg;
    assign cfg.center_z = center_z_reg;
    assign cfg.axis_sin = axis_sin_reg;
    assign cfg.axis_cos = axis_cos_reg;
    assign cfg.radius   = radius_reg;
    assign cfg.scale    = scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            axis_sin_reg <= '0;
            axis_cos_reg <= AXIS_COS_RESET;
            radius_reg   <= '0;
            scale_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_CENTER_X: center_x_reg <= cfg_data[COORD_W-1:0];
                REG_CENTER_Y: center_y_reg <= cfg_data[COORD_W-1:0];
                REG_CENTER_Z: center_z_reg <= cfg_data[COORD_W-1:0];
                REG_AXIS_SIN: axis_sin_reg <= cfg_data[TRIG_W-1:0];
                REG_AXIS_COS: axis_cos_reg <= cfg_data[TRIG_W-1:0];
                REG_RADIUS:   radius_reg   <= cfg_data[RAD_W-1:0];
                REG_SCALE:    scale_reg    <= cfg_data[SCALE_W-1:0];
                default:      ;
            endcase
        end
    end

    cgz_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_push   (q_push),
        .q_data   (q_push_data),
        .q_full   (q_full)
    );

    cgz_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    cgz_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    a_fault_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.divide_fault |->
            out_data.gravity_z == '0 && !out_data.saturated)
        else $error("Faulted transaction carries a non-zero result.");

    a_saturated_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.saturated |->
            $signed(out_data.gravity_z) == $signed(GZ_POS_LIMIT[GZ_W-1:0]) ||
            $signed(out_data.gravity_z) == $signed(GZ_NEG_LIMIT[GZ_W-1:0]))
        else $error("Saturated transaction is not at a range limit.");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> q_full)
        else $error("Input stalled while the queue has room.");

endmodule

/* tb/sv/cylinder_gravity_z_tb.sv */
// Testbench for the horizontal cylinder gravity block: directed and random points checked against a predictor.
module cylinder_gravity_z_tb;
    import cgz_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int IDLE_PCT       = 19;
    localparam int PHASE_ITEMS    = 225;
    localparam int RANDOM_PHASES  = 8;
    localparam int HOLDOFF_AT     = 800;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 80;
    localparam int QUIET_LIMIT    = 4000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    cfg_t      cyl_cfg;
    in_item_t  pending_obs[$];
    out_item_t gz_expected[$];
    bit        steady = 1'b0;
    int        mismatches = 0;
    int        results_seen = 0;
    int        holdoff_left = 0;
    bit        holdoff_done = 1'b0;
    int        quiet_cycles = 0;

    cylinder_gravity_z uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic out_item_t cylinder_gz(in_item_t obs);
        longint       dx, dy, dz, s, along, xy2, d2, r2, p;
        logic [127:0] mag, quo, r2w, d2w;
        logic         neg;
        out_item_t    res;
        dx = longint'($signed(obs.obs_x)) - longint'($signed(cyl_cfg.center_x));
        dy = longint'($signed(obs.obs_y)) - longint'($signed(cyl_cfg.center_y));
        dz = longint'($signed(obs.obs_z)) - longint'($signed(cyl_cfg.center_z));
        s = longint'($signed(cyl_cfg.axis_sin)) * dx + longint'($signed(cyl_cfg.axis_cos)) * dy;
        along = s >>> 15;
        xy2 = dx * dx + dy * dy - along * along;
        if (xy2 < 0)
            xy2 = 0;
        d2 = xy2 + dz * dz;
        r2 = longint'(cyl_cfg.radius) * longint'(cyl_cfg.radius);
        p = longint'($signed(cyl_cfg.scale)) * dz;
        neg = p < 0;
        mag = neg ? -p : p;
        r2w = r2;
        d2w = d2;
        res = '0;
        if (d2 >= r2 && d2 == 0)
        begin
            res.divide_fault = 1'b1;
            return res;
        end
        quo = (d2 >= r2) ? (mag * r2w) / d2w : mag;
        if (neg && quo > GZ_NEG_LIMIT)
        begin
            quo = GZ_NEG_LIMIT;
            res.saturated = 1'b1;
        end
        else if (!neg && quo > GZ_POS_LIMIT)
        begin
            quo = GZ_POS_LIMIT;
            res.saturated = 1'b1;
        end
        res.gravity_z = neg ? -quo[GZ_W-1:0] : quo[GZ_W-1:0];
        return res;
    endfunction

    function automatic in_item_t make_obs(int x, int y, int z);
        in_item_t obs;
        obs.obs_x = COORD_W'(x);
        obs.obs_y = COORD_W'(y);
        obs.obs_z = COORD_W'(z);
        return obs;
    endfunction

    function automatic in_item_t near_obs();
        int       span;
        in_item_t obs;
        span = int'(cyl_cfg.radius) * 2 + 8;
        if (span > 8388607)
            span = 8388607;
        obs.obs_x = cyl_cfg.center_x + COORD_W'(int'($urandom_range(2 * span)) - span);
        obs.obs_y = cyl_cfg.center_y + COORD_W'(int'($urandom_range(2 * span)) - span);
        obs.obs_z = cyl_cfg.center_z + COORD_W'(int'($urandom_range(2 * span)) - span);
        return obs;
    endfunction

    function automatic cfg_t random_setup(int phase);
        cfg_t c;
        c.center_x = COORD_W'($urandom);
        c.center_y = COORD_W'($urandom);
        c.center_z = COORD_W'($urandom);
        c.axis_sin = TRIG_W'($urandom);
        c.axis_cos = TRIG_W'($urandom);
        c.radius = ($urandom_range(1) == 0) ? RAD_W'($urandom_range(65535)) : RAD_W'($urandom);
        c.scale = SCALE_W'($urandom);
        case (phase)
            1:
            begin
                c.center_x = {1'b0, {(COORD_W-1){1'b1}}};
                c.center_y = {1'b0, {(COORD_W-1){1'b1}}};
                c.center_z = {1'b0, {(COORD_W-1){1'b1}}};
                c.scale = {1'b0, {(SCALE_W-1){1'b1}}};
            end
            2:
            begin
                c.center_x = {1'b1, {(COORD_W-1){1'b0}}};
                c.center_y = {1'b1, {(COORD_W-1){1'b0}}};
                c.center_z = {1'b1, {(COORD_W-1){1'b0}}};
                c.scale = {1'b1, {(SCALE_W-1){1'b0}}};
                c.radius = '1;
            end
            3:
            begin
                c.axis_sin = {1'b1, {(TRIG_W-1){1'b0}}};
                c.axis_cos = {1'b1, {(TRIG_W-1){1'b0}}};
            end
            4:
            begin
                c.axis_sin = {1'b0, {(TRIG_W-1){1'b1}}};
                c.axis_cos = {1'b0, {(TRIG_W-1){1'b1}}};
                c.radius = '0;
            end
            5:
                c.radius = '1;
            6:
            begin
                c.radius = '0;
                c.scale = '0;
            end
            default:
            begin
            end
        endcase
        return c;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_CENTER_X: cyl_cfg.center_x = val[COORD_W-1:0];
            REG_CENTER_Y: cyl_cfg.center_y = val[COORD_W-1:0];
            REG_CENTER_Z: cyl_cfg.center_z = val[COORD_W-1:0];
            REG_AXIS_SIN: cyl_cfg.axis_sin = val[TRIG_W-1:0];
            REG_AXIS_COS: cyl_cfg.axis_cos = val[TRIG_W-1:0];
            REG_RADIUS:   cyl_cfg.radius = val[RAD_W-1:0];
            REG_SCALE:    cyl_cfg.scale = val[SCALE_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic apply_setup(cfg_t c);
        write_reg(REG_CENTER_X, CFG_DATA_W'(c.center_x));
        write_reg(REG_CENTER_Y, CFG_DATA_W'(c.center_y));
        write_reg(REG_CENTER_Z, CFG_DATA_W'(c.center_z));
        write_reg(REG_AXIS_SIN, CFG_DATA_W'(c.axis_sin));
        write_reg(REG_AXIS_COS, CFG_DATA_W'(c.axis_cos));
        write_reg(REG_RADIUS, CFG_DATA_W'(c.radius));
        write_reg(REG_SCALE, CFG_DATA_W'(c.scale));
    endtask

    task automatic drain();
        while (pending_obs.size() != 0 || gz_expected.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        cfg_t     c;
        in_item_t obs;
        cyl_cfg = '0;
        cyl_cfg.axis_cos = AXIS_COS_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults, with a point on the axis of a zero-radius cylinder.
        write_reg(REG_UNUSED, '1);
        pending_obs.push_back(make_obs(0, 0, 0));
        pending_obs.push_back(make_obs(8388607, 8388607, 8388607));
        pending_obs.push_back(make_obs(-8388608, -8388608, -8388608));
        drain();

        c = '0;
        c.axis_cos = 16'sd32767;
        c.radius = 23'd1000;
        c.scale = 32'sd100000;
        apply_setup(c);
        pending_obs.push_back(make_obs(0, 0, 500));
        pending_obs.push_back(make_obs(0, 0, -500));
        pending_obs.push_back(make_obs(3000, 0, 0));
        pending_obs.push_back(make_obs(3000, 0, 3000));
        pending_obs.push_back(make_obs(0, 5000, 10));
        pending_obs.push_back(make_obs(8388607, -8388608, 8388607));
        pending_obs.push_back(make_obs(-8388608, 8388607, -8388608));
        drain();

        // The projection overshoots here, so the squared distance in the plane goes negative.
        c = '0;
        c.axis_sin = 16'sh8000;
        c.axis_cos = 16'sh8000;
        c.scale = -32'sd5;
        apply_setup(c);
        pending_obs.push_back(make_obs(100, 100, 0));
        pending_obs.push_back(make_obs(-7, -9, 0));
        pending_obs.push_back(make_obs(100, 100, 3));
        drain();

        // Large depth offsets drive the result past the 48-bit range in both directions.
        c = '0;
        c.center_z = 24'sh800000;
        c.axis_cos = 16'sd32767;
        c.radius = '1;
        c.scale = 32'sh7FFFFFFF;
        apply_setup(c);
        pending_obs.push_back(make_obs(0, 0, 8388607));
        pending_obs.push_back(make_obs(0, 0, -8388608));
        pending_obs.push_back(make_obs(0, 0, -8388000));
        drain();
        write_reg(REG_SCALE, 32'h80000000);
        pending_obs.push_back(make_obs(0, 0, 8388607));
        pending_obs.push_back(make_obs(-8388608, 8388607, 8388607));
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            apply_setup(random_setup(phase));
            steady <= (phase == 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(99) < 3)
                    obs = make_obs(cyl_cfg.center_x, cyl_cfg.center_y, cyl_cfg.center_z);
                else if ($urandom_range(99) < 60)
                    obs = near_obs();
                else
                    obs = make_obs($urandom, $urandom, $urandom);
                pending_obs.push_back(obs);
            end
            drain();
        end

        steady <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("cylinder_gravity_z test passed");
        else
            $display("cylinder_gravity_z test failed");
        $finish;
    end

    always @(posedge clk)
    begin : obs_driver
        if (in_valid && !in_stall)
        begin
            gz_expected.push_back(cylinder_gz(in_data));
            void'(pending_obs.pop_front());
        end
        if (in_valid && in_stall)
        begin
            in_valid <= 1'b1;
        end
        else if (pending_obs.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
        begin
            in_valid <= 1'b1;
            in_data <= pending_obs[0];
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : gz_monitor
        out_item_t want;
        if (out_valid && !out_stall)
        begin
            results_seen++;
            if (gz_expected.size() == 0)
            begin
                $error("result transaction with nothing expected: gravity_z %0d",
                       out_data.gravity_z);
                mismatches++;
            end
            else
            begin
                want = gz_expected.pop_front();
                if (out_data.gravity_z !== want.gravity_z)
                begin
                    $error("gravity_z mismatch: expected %0d, actual %0d",
                           want.gravity_z, out_data.gravity_z);
                    mismatches++;
                end
                if (out_data.divide_fault !== want.divide_fault)
                begin
                    $error("divide_fault mismatch: expected %0b, actual %0b",
                           want.divide_fault, out_data.divide_fault);
                    mismatches++;
                end
                if (out_data.saturated !== want.saturated)
                begin
                    $error("saturated mismatch: expected %0b, actual %0b",
                           want.saturated, out_data.saturated);
                    mismatches++;
                end
            end
        end
        if (!holdoff_done && results_seen >= HOLDOFF_AT)
        begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("cylinder_gravity_z test failed");
            $finish;
        end
    end

endmodule
